// ===== rtl/incremental_pid_step_top_macros.svh =====
// assertion macros shared by the pid step rtl
`ifndef INCREMENTAL_PID_STEP_TOP_MACROS_SVH
`define INCREMENTAL_PID_STEP_TOP_MACROS_SVH

// property checked on every rising clock edge outside reset
`define IPID_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold outside reset
`define IPID_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/ipid_pkg.sv =====
// shared widths, register indexes and types for the pid step block
`timescale 1ns / 1ps
package ipid_pkg;

  localparam int PosW   = 24;  // measured / setpoint, q16.8
  localparam int ErrW   = 25;  // error, q17.8
  localparam int D1W    = 26;  // first difference
  localparam int D2W    = 27;  // second difference
  localparam int GainW  = 16;  // q8.8 gains
  localparam int PerW   = 16;  // sample period, 16 fraction bits
  localparam int AccW   = 64;  // product and sum width
  localparam int OutW   = 32;  // drive delta, q24.8
  localparam int QuoW   = 58;  // quotient bits of the derivative divide
  localparam int MulLen = 16;  // multiplier bits, one per cycle
  localparam int CntW   = 6;   // step counter, holds QuoW - 1
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegGainP  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainI  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainD  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPeriod = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMode   = 3'd4;

  localparam logic [PerW-1:0] PeriodReset = 16'd66;

  typedef logic signed [AccW-1:0] acc_t;

endpackage

// ===== rtl/incremental_pid_step_top.sv =====
// incremental pid step: bit-serial multiplies and divide under one sequencer
// sequence: the four products in turn (proportional, integral gain, integral period,
//   derivative), then in divide mode the derivative divided by the period, then rounding
// a new item is taken only back in idle, after the last result is in the output
//   register; the shift-add multiplier and restoring divider handle one bit per cycle
// reset: asynchronous active low; gains and mode clear, period 66, errors zero
`timescale 1ns / 1ps
`include "incremental_pid_step_top_macros.svh"
module incremental_pid_step_top import ipid_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input items
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [47:0]        s_axis_tdata_i,   // [23:0] measured, [47:24] setpoint
  // result items
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [31:0]        m_axis_tdata_o,   // [31:0] drive_delta
  output logic               m_axis_tuser_o,   // [0] clipped
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an item
  localparam logic [2:0] S_MUL  = 3'd1;  // one multiplier bit per cycle
  localparam logic [2:0] S_POST = 3'd2;  // fold product into sum or next operand, start next multiply or divide
  localparam logic [2:0] S_DIV  = 3'd3;  // one quotient bit per cycle
  localparam logic [2:0] S_DFIN = 3'd4;  // add signed quotient into sum
  localparam logic [2:0] S_DONE = 3'd5;  // round, saturate, hand to output register

  // which product the multiplier is working on
  localparam logic [1:0] PH_P  = 2'd0;  // gain_p * (e - e1)
  localparam logic [1:0] PH_I1 = 2'd1;  // gain_i * e
  localparam logic [1:0] PH_I2 = 2'd2;  // (gain_i * e) * period
  localparam logic [1:0] PH_D  = 2'd3;  // gain_d * (e - 2 e1 + e2)

  // configuration registers
  logic signed [GainW-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [PerW-1:0]         period_q;
  logic                    mode_q;

  // error history, e1 holds the current error once the item is taken
  logic signed [ErrW-1:0]  err_last_q, err_prev_q;
  logic signed [D2W-1:0]   d2_q;

  // sequencer and datapath registers
  logic [2:0]              state_q, state_d;
  logic [1:0]              ph_q, ph_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  acc_t                    mcand_q, mcand_d;   // shifts left one bit a cycle
  logic [MulLen-1:0]       mplier_q, mplier_d; // shifts right one bit a cycle
  logic                    msigned_q, msigned_d;
  acc_t                    prod_q, prod_d;
  acc_t                    sum_q, sum_d;
  logic [QuoW-1:0]         quo_q, quo_d;       // dividend shifts out, quotient shifts in
  logic [PerW-1:0]         rem_q, rem_d;
  logic                    neg_q, neg_d;
  logic [OutW-1:0]         out_data_q, out_data_d;
  logic                    out_clip_q, out_clip_d;
  logic                    out_valid_q, out_valid_d;

  // front end: error and differences, formed in the accept cycle
  logic signed [PosW-1:0]  meas, setp;
  logic signed [ErrW-1:0]  err_new;
  logic signed [D1W-1:0]   d1;
  logic signed [D2W-1:0]   d2;
  logic                    in_fire;

  assign meas    = signed'(s_axis_tdata_i[PosW-1:0]);
  assign setp    = signed'(s_axis_tdata_i[2*PosW-1:PosW]);
  assign err_new = ErrW'(setp) - ErrW'(meas);
  assign d1      = D1W'(err_new) - D1W'(err_last_q);
  assign d2      = D2W'(err_new) - (D2W'(err_last_q) <<< 1) + D2W'(err_prev_q);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // multiplier step; the top bit of a signed multiplier has negative weight
  acc_t mul_term;
  logic mul_last;
  assign mul_last = (cnt_q == CntW'(MulLen - 1));
  always_comb begin
    if (!mplier_q[0]) begin
      mul_term = '0;
    end else if (msigned_q && mul_last) begin
      mul_term = -mcand_q;
    end else begin
      mul_term = mcand_q;
    end
  end

  // integral rounding: floor((x + 2^15) / 2^16) = floor(x / 2^16) + x[15]
  acc_t i_term;
  assign i_term = prod_q >>> 16;

  // derivative magnitude and divisor (zero period divides by one)
  acc_t            d_mag;
  logic [PerW-1:0] divisor;
  logic [PerW:0]   rem_sh, rem_diff;
  logic            q_bit;
  assign d_mag    = prod_q[AccW-1] ? -prod_q : prod_q;
  assign divisor  = (period_q == '0) ? PerW'(1) : period_q;
  assign rem_sh   = {rem_q, quo_q[QuoW-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign q_bit    = (rem_sh >= {1'b0, divisor});

  // final rounding and saturation
  acc_t rnd;
  logic sat;
  assign rnd = sum_q + acc_t'(128);
  assign sat = !((&rnd[AccW-1:OutW+7]) || !(|rnd[AccW-1:OutW+7]));

  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    cnt_d       = cnt_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    msigned_d   = msigned_q;
    prod_d      = prod_q;
    sum_d       = sum_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    out_data_d  = out_data_q;
    out_clip_d  = out_clip_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          mcand_d   = acc_t'(d1);
          mplier_d  = gain_p_q;
          msigned_d = 1'b1;
          prod_d    = '0;
          cnt_d     = '0;
          ph_d      = PH_P;
          state_d   = S_MUL;
        end
      end
      S_MUL: begin
        prod_d   = prod_q + mul_term;
        mcand_d  = mcand_q <<< 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + CntW'(1);
        if (mul_last) begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        cnt_d   = '0;
        prod_d  = '0;
        state_d = S_MUL;
        case (ph_q)
          PH_P: begin
            sum_d     = prod_q;
            mcand_d   = acc_t'(err_last_q);
            mplier_d  = gain_i_q;
            msigned_d = 1'b1;
            ph_d      = PH_I1;
          end
          PH_I1: begin
            mcand_d   = prod_q;
            mplier_d  = period_q;
            msigned_d = 1'b0;
            ph_d      = PH_I2;
          end
          PH_I2: begin
            sum_d     = sum_q + i_term + {{(AccW-1){1'b0}}, prod_q[15]};
            mcand_d   = acc_t'(d2_q);
            mplier_d  = gain_d_q;
            msigned_d = 1'b1;
            ph_d      = PH_D;
          end
          PH_D: begin
            if (mode_q) begin
              // (|d_raw| * 2^16) / T, sign put back afterwards
              quo_d   = {d_mag[QuoW-17:0], 16'b0};
              rem_d   = '0;
              neg_d   = prod_q[AccW-1];
              state_d = S_DIV;
            end else begin
              sum_d   = sum_q + prod_q;
              state_d = S_DONE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_DIV: begin
        rem_d = q_bit ? rem_diff[PerW-1:0] : rem_sh[PerW-1:0];
        quo_d = {quo_q[QuoW-2:0], q_bit};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(QuoW - 1)) begin
          state_d = S_DFIN;
        end
      end
      S_DFIN: begin
        if (neg_q) begin
          sum_d = sum_q - acc_t'({{(AccW-QuoW){1'b0}}, quo_q});
        end else begin
          sum_d = sum_q + acc_t'({{(AccW-QuoW){1'b0}}, quo_q});
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        // wait here while the previous result is still not taken
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_clip_d  = sat;
          if (!sat) begin
            out_data_d = rnd[OutW+7:8];
          end else if (rnd[AccW-1]) begin
            out_data_d = {1'b1, {(OutW-1){1'b0}}};
          end else begin
            out_data_d = {1'b0, {(OutW-1){1'b1}}};
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_q        <= PH_P;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      period_q    <= PeriodReset;
      mode_q      <= 1'b0;
      err_last_q  <= '0;
      err_prev_q  <= '0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegGainP:  gain_p_q <= signed'(cfg_wdata_i);
          RegGainI:  gain_i_q <= signed'(cfg_wdata_i);
          RegGainD:  gain_d_q <= signed'(cfg_wdata_i);
          RegPeriod: period_q <= cfg_wdata_i;
          RegMode:   mode_q   <= cfg_wdata_i[0];
          default: ;  // unknown index, write dropped
        endcase
      end
      // error history shifts as the item is taken
      if (in_fire) begin
        err_prev_q <= err_last_q;
        err_last_q <= err_new;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    mcand_q    <= mcand_d;
    mplier_q   <= mplier_d;
    msigned_q  <= msigned_d;
    prod_q     <= prod_d;
    sum_q      <= sum_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    neg_q      <= neg_d;
    out_data_q <= out_data_d;
    out_clip_q <= out_clip_d;
    if (in_fire) begin
      d2_q <= d2;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_clip_q;

  // an accepted item always starts with the proportional product
  `IPID_ASSERT(a_start_p, in_fire |=> (state_q == S_MUL && ph_q == PH_P && cnt_q == '0), "item did not start the proportional multiply")
  // a new result only comes out of the final rounding state
  `IPID_ASSERT(a_result_src, $rose(out_valid_q) |-> $past(state_q) == S_DONE, "result appeared outside the rounding step")
  // a clipped result carries one of the two range limits
  `IPID_ASSERT(a_clip_value, (out_valid_q && out_clip_q) |-> (out_data_q == 32'h7fff_ffff || out_data_q == 32'h8000_0000), "clipped result is not a range limit")
  // the multiply counter never runs past the multiplier width
  `IPID_ASSERT_NEVER(a_mul_cnt, state_q == S_MUL && cnt_q > CntW'(MulLen - 1), "multiply counter overran")

endmodule
